@@ src/vpts_pkg.sv @@
package vpts_pkg;

    // input commands
    localparam logic CMD_TRANSFORM = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_VIEWPORT_WIDTH  = 1'b0;
    localparam logic REG_VIEWPORT_HEIGHT = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // magnitude limit (log2) of x/w and y/w before pixel mapping
    localparam int XY_LIM = 17;
    // depth keeps 32 bits of result
    localparam int DEPTH_BITS = 32;

    localparam logic signed [15:0] PIX_MAX = 16'sh7fff;
    localparam logic signed [15:0] PIX_MIN = -16'sh8000;
    localparam logic signed [31:0] DEPTH_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] DEPTH_MIN = -32'sh80000000;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
    } viewport_cfg_t;

endpackage

@@ src/vpts_point_if.sv @@
interface vpts_point_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;

    modport source (output valid, command, coef_index, coef_value, x_coord, y_coord, z_coord,
                    input ready);
    modport sink   (input valid, command, coef_index, coef_value, x_coord, y_coord, z_coord,
                    output ready);
endinterface

@@ src/vpts_result_if.sv @@
interface vpts_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [31:0] depth;
    logic               w_zero;

    modport source (output valid, screen_x, screen_y, depth, w_zero, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, w_zero, output ready);
endinterface

@@ src/vpts_front.sv @@
module vpts_front #(
    parameter int FRAC_BITS = 16,
    parameter int SUM_W     = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    vpts_point_if.sink           points,
    output logic                 s_valid,
    input  logic                 s_ready,
    output logic [4*SUM_W-1:0]   s_data
);

    logic signed [31:0] mat_reg [0:15];

    logic               p_v_reg;
    logic signed [63:0] prod_reg [0:11];
    logic signed [31:0] bias_reg [0:3];

    logic               s_v_reg;
    logic signed [SUM_W-1:0] sum_reg [0:3];
    logic signed [SUM_W-1:0] sum_next [0:3];

    logic fe;
    logic take;

    assign fe = !s_v_reg || s_ready;
    assign points.ready = fe;
    assign take = points.valid && fe;

    // matrix: loads land at the transfer edge, products use the old contents
    always_ff @(posedge clk)
    begin
        if (take && points.command == vpts_pkg::CMD_LOAD)
        begin
            mat_reg[points.coef_index] <= points.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            p_v_reg <= take && points.command == vpts_pkg::CMD_TRANSFORM;
            s_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r*3]   <= mat_reg[r*4]   * points.x_coord;
                prod_reg[r*3+1] <= mat_reg[r*4+1] * points.y_coord;
                prod_reg[r*3+2] <= mat_reg[r*4+2] * points.z_coord;
                bias_reg[r]     <= mat_reg[r*4+3];
                sum_reg[r]      <= sum_next[r];
            end
        end
    end

    // floor shift of each product, then exact row sum
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r*3] >>> FRAC_BITS)
                        + SUM_W'(prod_reg[r*3+1] >>> FRAC_BITS)
                        + SUM_W'(prod_reg[r*3+2] >>> FRAC_BITS)
                        + SUM_W'(bias_reg[r]);
        end
    end

    assign s_valid = s_v_reg;
    assign s_data  = {sum_reg[3], sum_reg[2], sum_reg[1], sum_reg[0]};

endmodule

@@ src/vpts_fifo.sv @@
module vpts_fifo #(
    parameter int W     = 200,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          push, pop;

    assign wr_ready = cnt_reg != CW'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

@@ src/vpts_back.sv @@
module vpts_back #(
    parameter int FRAC_BITS = 16,
    parameter int SUM_W     = 50
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [4*SUM_W-1:0]     s_data,
    input  vpts_pkg::viewport_cfg_t cfg,
    vpts_result_if.source          results
);

    localparam int LIM = (vpts_pkg::DEPTH_BITS - FRAC_BITS > vpts_pkg::XY_LIM)
                       ? vpts_pkg::DEPTH_BITS - FRAC_BITS : vpts_pkg::XY_LIM;
    localparam int QW  = LIM + FRAC_BITS;
    localparam int MW  = QW + 1;
    localparam int XW  = vpts_pkg::XY_LIM + FRAC_BITS + 1;
    localparam int QS  = XW + 1;
    localparam int TW  = QS + 17;

    logic en;

    // entry decode
    logic signed [SUM_W-1:0] num [0:2];
    logic signed [SUM_W-1:0] den;
    logic [SUM_W-1:0] absn [0:2];
    logic [SUM_W-1:0] absd;

    // divider stages, one quotient bit each
    logic             dv_v_reg [0:QW];
    logic [SUM_W-1:0] d_reg    [0:QW];
    logic             wz_reg   [0:QW];
    logic [SUM_W-1:0] rem_reg  [0:QW][0:2];
    logic [QW-1:0]    dv_reg   [0:QW][0:2];
    logic [QW-1:0]    q_reg    [0:QW][0:2];
    logic             ov_reg   [0:QW][0:2];
    logic             neg_reg  [0:QW][0:2];
    logic             nneg_reg [0:QW][0:2];

    logic [SUM_W:0]   trial     [1:QW][0:2];
    logic             qb_next   [1:QW][0:2];
    logic [SUM_W-1:0] rem_next  [1:QW][0:2];

    // mapping stages
    logic [MW-1:0]        mag [0:2];
    logic [MW-1:0]        magxy [0:1];
    logic signed [QS-1:0] qxy_next [0:1];
    logic signed [31:0]   dep_next;

    logic                 p1_v_reg, p1_wz_reg;
    logic                 p1_nneg_reg [0:2];
    logic signed [QS-1:0] p1_q_reg [0:1];
    logic signed [31:0]   p1_dep_reg;

    logic                 p2_v_reg, p2_wz_reg;
    logic                 p2_nneg_reg [0:2];
    logic signed [TW-1:0] p2_t_reg [0:1];
    logic signed [31:0]   p2_dep_reg;

    logic signed [TW-1:0] tr [0:1];
    logic signed [TW-1:0] px [0:1];
    logic signed [15:0]   pix_next [0:1];

    logic                 o_v_reg;
    logic signed [15:0]   o_x_reg, o_y_reg;
    logic signed [31:0]   o_dep_reg;
    logic                 o_wz_reg;

    assign en = !o_v_reg || results.ready;
    assign s_ready = en;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l]  = s_data[l*SUM_W +: SUM_W];
            absn[l] = num[l][SUM_W-1] ? SUM_W'(-num[l]) : SUM_W'(num[l]);
        end
        den  = s_data[3*SUM_W +: SUM_W];
        absd = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    end

    always_comb
    begin
        for (int k = 1; k <= QW; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[k][l]   = {rem_reg[k-1][l], dv_reg[k-1][l][QW-1]};
                qb_next[k][l] = trial[k][l] >= {1'b0, d_reg[k-1]};
                rem_next[k][l] = qb_next[k][l]
                               ? SUM_W'(trial[k][l] - {1'b0, d_reg[k-1]})
                               : trial[k][l][SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= s_valid;
            for (int k = 1; k <= QW; k++)
            begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            p1_v_reg <= dv_v_reg[QW];
            p2_v_reg <= p1_v_reg;
            o_v_reg  <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]  <= absd;
            wz_reg[0] <= absd == '0;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l]  <= absn[l] >> LIM;
                dv_reg[0][l]   <= {absn[l][LIM-1:0], {FRAC_BITS{1'b0}}};
                q_reg[0][l]    <= '0;
                ov_reg[0][l]   <= (absn[l] >> LIM) >= absd;
                neg_reg[0][l]  <= num[l][SUM_W-1] ^ den[SUM_W-1];
                nneg_reg[0][l] <= num[l][SUM_W-1];
            end
            for (int k = 1; k <= QW; k++)
            begin
                d_reg[k]  <= d_reg[k-1];
                wz_reg[k] <= wz_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k][l]  <= rem_next[k][l];
                    dv_reg[k][l]   <= {dv_reg[k-1][l][QW-2:0], 1'b0};
                    q_reg[k][l]    <= {q_reg[k-1][l][QW-2:0], qb_next[k][l]};
                    ov_reg[k][l]   <= ov_reg[k-1][l];
                    neg_reg[k][l]  <= neg_reg[k-1][l];
                    nneg_reg[k][l] <= nneg_reg[k-1][l];
                end
            end
        end
    end

    // clamp, sign and depth saturation
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mag[l] = ov_reg[QW][l] ? (MW'(1) << QW) : {1'b0, q_reg[QW][l]};
        end
        for (int l = 0; l < 2; l++)
        begin
            magxy[l] = (mag[l] > (MW'(1) << (XW - 1))) ? (MW'(1) << (XW - 1)) : mag[l];
            qxy_next[l] = neg_reg[QW][l] ? -$signed({1'b0, magxy[l][XW-1:0]})
                                         : $signed({1'b0, magxy[l][XW-1:0]});
        end
        if (neg_reg[QW][2])
        begin
            dep_next = (mag[2] >= (MW'(1) << 31)) ? vpts_pkg::DEPTH_MIN
                                                  : 32'(-$signed({1'b0, mag[2]}));
        end
        else
        begin
            dep_next = (mag[2] >= (MW'(1) << 31)) ? vpts_pkg::DEPTH_MAX : $signed(mag[2][31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_wz_reg  <= wz_reg[QW];
            p1_dep_reg <= dep_next;
            for (int l = 0; l < 3; l++)
            begin
                p1_nneg_reg[l] <= nneg_reg[QW][l];
            end
            p1_q_reg[0] <= qxy_next[0];
            p1_q_reg[1] <= qxy_next[1];

            p2_wz_reg   <= p1_wz_reg;
            p2_dep_reg  <= p1_dep_reg;
            for (int l = 0; l < 3; l++)
            begin
                p2_nneg_reg[l] <= p1_nneg_reg[l];
            end
            p2_t_reg[0] <= TW'(p1_q_reg[0] + QS'(1 << FRAC_BITS))
                         * $signed({1'b0, cfg.width});
            p2_t_reg[1] <= TW'(p1_q_reg[1] + QS'(1 << FRAC_BITS))
                         * $signed({1'b0, cfg.height});
        end
    end

    // divide by 2^(FRAC_BITS+1) toward zero, saturate to 16 bits
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            tr[l] = p2_t_reg[l][TW-1]
                  ? p2_t_reg[l] + TW'((1 << (FRAC_BITS + 1)) - 1)
                  : p2_t_reg[l];
            px[l] = tr[l] >>> (FRAC_BITS + 1);
            if (p2_wz_reg)
            begin
                pix_next[l] = p2_nneg_reg[l] ? vpts_pkg::PIX_MIN : vpts_pkg::PIX_MAX;
            end
            else if (px[l] > TW'(vpts_pkg::PIX_MAX))
            begin
                pix_next[l] = vpts_pkg::PIX_MAX;
            end
            else if (px[l] < TW'(vpts_pkg::PIX_MIN))
            begin
                pix_next[l] = vpts_pkg::PIX_MIN;
            end
            else
            begin
                pix_next[l] = px[l][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg   <= pix_next[0];
            o_y_reg   <= pix_next[1];
            o_wz_reg  <= p2_wz_reg;
            o_dep_reg <= p2_wz_reg ? (p2_nneg_reg[2] ? vpts_pkg::DEPTH_MIN : vpts_pkg::DEPTH_MAX)
                                   : p2_dep_reg;
        end
    end

    assign results.valid    = o_v_reg;
    assign results.screen_x = o_x_reg;
    assign results.screen_y = o_y_reg;
    assign results.depth    = o_dep_reg;
    assign results.w_zero   = o_wz_reg;

endmodule

@@ src/vertex_project_to_screen.sv @@
// Perspective vertex projector: (x, y, z, 1) times a stored 4x4 Q16.16
// matrix, divide by w, map x and y to pixels, output z/w as depth.
//
// Channels: points (sink) carries load and transform commands; results
// (source) carries one transfer per transform and none per load. Both use
// valid/ready, a transfer happens when both are high at a clock edge.
// Configuration: APB write of viewport_width at 0x0, viewport_height at 0x4.
// The user must change registers only while the block is idle; the block does not enforce it.
//
// Throughput: one point per cycle, sustained, while results.ready is high.
// The restoring divider, one quotient bit per stage, sets most of the
// pipeline length; its quotient is LIM + FRAC_BITS bits, LIM = max(17, 32 - F).
// Loads take effect at their transfer; earlier points still use the old
// matrix. The matrix is not cleared at reset and must be loaded first.
//
// Reset clears all valid flags and sets both viewport sizes to 1. When the
// receiver stalls, the back pipeline holds; the front keeps taking points
// until the 4-entry queue fills, then drops points.ready.
module vertex_project_to_screen #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vpts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [vpts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vpts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    vpts_point_if.sink                        points,
    vpts_result_if.source                     results
);

    // row sum width: three floor-shifted products plus the bias term
    localparam int SUM_W   = 66 - FRAC_BITS;
    localparam int Q_DEPTH = 4;

    vpts_pkg::viewport_cfg_t cfg_reg;

    logic               f_valid, f_ready;
    logic [4*SUM_W-1:0] f_data;
    logic               b_valid, b_ready;
    logic [4*SUM_W-1:0] b_data;

    assign pready = 1'b1;

    // APB register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 16'd1;
            cfg_reg.height <= 16'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                vpts_pkg::REG_VIEWPORT_WIDTH:  cfg_reg.width  <= pwdata[15:0];
                vpts_pkg::REG_VIEWPORT_HEIGHT: cfg_reg.height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            vpts_pkg::REG_VIEWPORT_WIDTH:  prdata = {16'd0, cfg_reg.width};
            vpts_pkg::REG_VIEWPORT_HEIGHT: prdata = {16'd0, cfg_reg.height};
            default:                       prdata = '0;
        endcase
    end

    // front: accept, matrix load, multiply and row sums
    vpts_front #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .s_valid (f_valid),
        .s_ready (f_ready),
        .s_data  (f_data)
    );

    // decoupling queue of homogeneous points
    vpts_fifo #(
        .W     (4 * SUM_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    // back: perspective divide and viewport mapping
    vpts_back #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (b_valid),
        .s_ready (b_ready),
        .s_data  (b_data),
        .cfg     (cfg_reg),
        .results (results)
    );

endmodule
